FILE: hdl/bgcd_pkg.sv
package bgcd_pkg;

  // Default datapath width of the cell row.
  localparam int unsigned DefDataWidth = 32;

  // Width of the operand and result fields on the ports.
  localparam int unsigned FieldWidth = 32;

  // Command broadcast to every cell of the row in a cycle.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SHR_BOTH,
    OP_SHR_A,
    OP_SHR_B,
    OP_SUB,
    OP_SHL_A
  } op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SHARED,
    ST_STRIP_A,
    ST_LOOP,
    ST_RESTORE
  } state_t;

  // Status gathered from the cell row.
  typedef struct packed {
    logic a_lsb;
    logic b_lsb;
    logic a_zero;
    logic b_zero;
  } row_status_t;

  // Commands from the sequencer to the row and to the result register.
  typedef struct packed {
    op_t  op;
    logic emit;
    logic emit_sel_b;
  } ctrl_t;

endpackage

FILE: hdl/binary_gcd_unit.sv
// Binary (Stein) GCD over a row of one-bit cells driven by a sequencer.
// The done strobe is registered from a result given in the check state when an operand is zero,
// else in the restore state, after the shared-twos, strip-a and subtract-loop states have
// run and the shared twos have been shifted back into a.
// The receiver cannot stall; a new start is taken in the cycle the result is shown,
// so the item interval equals the latency. Synchronous active-high reset idles it.
module binary_gcd_unit
  import bgcd_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DefDataWidth
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [FieldWidth-1:0] operand_a,
  input  logic [FieldWidth-1:0] operand_b,
  output logic                  busy,
  output logic                  done,
  output logic [FieldWidth-1:0] divisor
);

  // Cell i holds bit i of both a and b. Right shifts take the bit of the
  // cell above, left shifts the bit of the cell below. The borrow of b - a
  // and of a - b ripple upward, and the borrow out of the top cell tells
  // every cell whether b < a, i.e. whether the subtract step must swap.
  logic [DATA_WIDTH-1:0] a_bits;
  logic [DATA_WIDTH-1:0] b_bits;
  logic [DATA_WIDTH:0]   borrow_ba;
  logic [DATA_WIDTH:0]   borrow_ab;
  logic [DATA_WIDTH:0]   a_zero_chain;
  logic [DATA_WIDTH:0]   b_zero_chain;
  logic [DATA_WIDTH-1:0] ld_a;
  logic [DATA_WIDTH-1:0] ld_b;
  logic [DATA_WIDTH-1:0] a_up;
  logic [DATA_WIDTH-1:0] b_up;
  logic [DATA_WIDTH-1:0] a_dn;
  logic [FieldWidth-1:0] a_field;
  logic [FieldWidth-1:0] b_field;
  row_status_t           status;
  ctrl_t                 ctrl;

  assign borrow_ba[0]    = 1'b0;
  assign borrow_ab[0]    = 1'b0;
  assign a_zero_chain[0] = 1'b1;
  assign b_zero_chain[0] = 1'b1;

  // Operands wrap to the datapath width; a wider datapath zero-extends them.
  // The result never exceeds an operand, so its low field bits are all of it.
  genvar i;
  generate
    for (i = 0; i < DATA_WIDTH; i++) begin : g_ld
      if (i < FieldWidth) begin : g_in
        assign ld_a[i] = operand_a[i];
        assign ld_b[i] = operand_b[i];
      end else begin : g_ext
        assign ld_a[i] = 1'b0;
        assign ld_b[i] = 1'b0;
      end
    end
    for (i = 0; i < FieldWidth; i++) begin : g_out
      if (i < DATA_WIDTH) begin : g_row
        assign a_field[i] = a_bits[i];
        assign b_field[i] = b_bits[i];
      end else begin : g_pad
        assign a_field[i] = 1'b0;
        assign b_field[i] = 1'b0;
      end
    end
  endgenerate

  assign a_up = {1'b0, a_bits[DATA_WIDTH-1:1]};
  assign b_up = {1'b0, b_bits[DATA_WIDTH-1:1]};
  assign a_dn = {a_bits[DATA_WIDTH-2:0], 1'b0};

  generate
    for (i = 0; i < DATA_WIDTH; i++) begin : g_cell
      bgcd_cell u_cell (
        .clk          (clk),
        .op           (ctrl.op),
        .ld_a         (ld_a[i]),
        .ld_b         (ld_b[i]),
        .a_up         (a_up[i]),
        .b_up         (b_up[i]),
        .a_dn         (a_dn[i]),
        .swap         (borrow_ba[DATA_WIDTH]),
        .borrow_ba_in (borrow_ba[i]),
        .borrow_ab_in (borrow_ab[i]),
        .a_zero_in    (a_zero_chain[i]),
        .b_zero_in    (b_zero_chain[i]),
        .a            (a_bits[i]),
        .b            (b_bits[i]),
        .borrow_ba_out(borrow_ba[i+1]),
        .borrow_ab_out(borrow_ab[i+1]),
        .a_zero_out   (a_zero_chain[i+1]),
        .b_zero_out   (b_zero_chain[i+1])
      );
    end
  endgenerate

  assign status.a_lsb  = a_bits[0];
  assign status.b_lsb  = b_bits[0];
  assign status.a_zero = a_zero_chain[DATA_WIDTH];
  assign status.b_zero = b_zero_chain[DATA_WIDTH];

  bgcd_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  // Result register: the row may start on the next item while the result of
  // this one is shown for its single cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      divisor <= ctrl.emit_sel_b ? b_field : a_field;
    end
  end

endmodule

FILE: hdl/bgcd_cell.sv
module bgcd_cell
  import bgcd_pkg::*;
(
  input  logic clk,
  input  op_t  op,
  input  logic ld_a,
  input  logic ld_b,
  input  logic a_up,
  input  logic b_up,
  input  logic a_dn,
  input  logic swap,
  input  logic borrow_ba_in,
  input  logic borrow_ab_in,
  input  logic a_zero_in,
  input  logic b_zero_in,
  output logic a,
  output logic b,
  output logic borrow_ba_out,
  output logic borrow_ab_out,
  output logic a_zero_out,
  output logic b_zero_out
);

  logic a_next;
  logic b_next;
  logic diff_ba;
  logic diff_ab;

  // One bit of b - a and of a - b; the borrows ripple toward the top cell.
  assign diff_ba       = b ^ a ^ borrow_ba_in;
  assign borrow_ba_out = (~b & a) | (~(b ^ a) & borrow_ba_in);
  assign diff_ab       = a ^ b ^ borrow_ab_in;
  assign borrow_ab_out = (~a & b) | (~(a ^ b) & borrow_ab_in);

  assign a_zero_out = a_zero_in & ~a;
  assign b_zero_out = b_zero_in & ~b;

  always_comb begin
    a_next = a;
    b_next = b;
    case (op)
      OP_LOAD: begin
        a_next = ld_a;
        b_next = ld_b;
      end
      OP_SHR_BOTH: begin
        a_next = a_up;
        b_next = b_up;
      end
      OP_SHR_A: a_next = a_up;
      OP_SHR_B: b_next = b_up;
      OP_SUB: begin
        if (swap) begin
          a_next = b;
          b_next = diff_ab;
        end else begin
          b_next = diff_ba;
        end
      end
      OP_SHL_A: a_next = a_dn;
      default: begin
        a_next = a;
        b_next = b;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    a <= a_next;
    b <= b_next;
  end

endmodule

FILE: hdl/bgcd_ctrl.sv
module bgcd_ctrl
  import bgcd_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DefDataWidth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  row_status_t status,
  output logic        busy,
  output ctrl_t       ctrl
);

  localparam int unsigned CntWidth = $clog2(DATA_WIDTH);

  state_t state;
  state_t state_next;
  logic [CntWidth-1:0] shared;
  logic [CntWidth-1:0] shared_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (start) state_next = ST_CHECK;
      ST_CHECK: begin
        if (status.a_zero || status.b_zero) state_next = ST_IDLE;
        else state_next = ST_SHARED;
      end
      ST_SHARED:  if (status.a_lsb || status.b_lsb) state_next = ST_STRIP_A;
      ST_STRIP_A: if (status.a_lsb) state_next = ST_LOOP;
      ST_LOOP:    if (status.b_zero) state_next = ST_RESTORE;
      ST_RESTORE: if (shared == '0) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl        = '{op: OP_HOLD, emit: 1'b0, emit_sel_b: 1'b0};
    shared_next = shared;
    unique case (state)
      ST_IDLE: begin
        shared_next = '0;
        if (start) ctrl.op = OP_LOAD;
      end
      ST_CHECK: begin
        // A zero operand gives the other one straight away.
        if (status.a_zero || status.b_zero) begin
          ctrl.emit       = 1'b1;
          ctrl.emit_sel_b = status.a_zero;
        end
      end
      ST_SHARED: begin
        if (!status.a_lsb && !status.b_lsb) begin
          ctrl.op     = OP_SHR_BOTH;
          shared_next = shared + 1'b1;
        end
      end
      ST_STRIP_A: if (!status.a_lsb) ctrl.op = OP_SHR_A;
      ST_LOOP: begin
        if (!status.b_zero) begin
          if (status.b_lsb) ctrl.op = OP_SUB;
          else ctrl.op = OP_SHR_B;
        end
      end
      ST_RESTORE: begin
        if (shared != '0) begin
          ctrl.op     = OP_SHL_A;
          shared_next = shared - 1'b1;
        end else begin
          ctrl.emit = 1'b1;
        end
      end
      default: ctrl.op = OP_HOLD;
    endcase
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      shared <= '0;
    end else begin
      state  <= state_next;
      shared <= shared_next;
    end
  end

  // The odd value sits in a for the whole subtract loop.
  a_odd_in_loop: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOOP |-> status.a_lsb)
    else $error("a is even in the subtract loop");

  // The power of two is only restored once the difference has vanished.
  b_zero_in_restore: assert property (@(posedge clk) disable iff (rst)
    state == ST_RESTORE |-> status.b_zero)
    else $error("b is nonzero while restoring shared twos");

  // Every result ends the item.
  emit_to_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |=> state == ST_IDLE)
    else $error("sequencer did not return to idle after a result");

  // Each shared halving is counted.
  shared_counts: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_SHR_BOTH |=> shared == $past(shared) + 1'b1)
    else $error("shared factor count did not advance");

endmodule

FILE: tb/tb_binary_gcd_unit.sv
// Self-checking testbench for the binary (Stein) GCD unit.
//
// The driver presents operand pairs with a start/busy command handshake and the
// monitor checks every done strobe against a predicted greatest common divisor.
// Operand pairs come from a queue that the stimulus block fills before reset is
// released. The driver pulls from that queue at the falling edge. The monitor
// samples at the rising edge, predicts the result of each accepted transfer, and
// compares the divisor shown with each done strobe against the oldest prediction.
module tb_binary_gcd_unit;
  import bgcd_pkg::*;

  // The unit is built with its default datapath width.
  localparam int unsigned DataWidth = DefDataWidth;

  // Upper bound on the cycles one item may take, used for the drain at the end.
  localparam int unsigned DrainCycles = 8 * DataWidth;

  typedef struct {
    logic [FieldWidth-1:0] a;
    logic [FieldWidth-1:0] b;
  } operand_pair_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic [FieldWidth-1:0] operand_a = '0;
  logic [FieldWidth-1:0] operand_b = '0;
  logic                  busy;
  logic                  done;
  logic [FieldWidth-1:0] divisor;

  // Pairs still waiting to be driven, and divisors still waiting to be shown.
  operand_pair_t         pending_pairs[$];
  logic [FieldWidth-1:0] expected_divisors[$];

  // The monitor tells the driver that the pair on the ports was transferred.
  logic                  taken = 1'b0;
  operand_pair_t         next_pair;

  int unsigned directed_count = 0;
  int unsigned driven_count = 0;
  int unsigned accepted_count = 0;
  int unsigned checked_count = 0;
  int unsigned zero_operand_count = 0;
  int unsigned shared_two_count = 0;
  int unsigned mismatches = 0;

  binary_gcd_unit #(
    .DATA_WIDTH(DataWidth)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .busy     (busy),
    .done     (done),
    .divisor  (divisor)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stein's algorithm on operands reduced to the datapath width. A zero operand
  // yields the other operand, so both zero yields zero.
  function automatic logic [FieldWidth-1:0] gcd_of(logic [FieldWidth-1:0] a_in,
                                                   logic [FieldWidth-1:0] b_in);
    bit [63:0]   width_mask;
    bit [63:0]   x;
    bit [63:0]   y;
    bit [63:0]   t;
    bit [63:0]   g;
    int unsigned twos;
    width_mask = (DataWidth >= 64) ? '1 : ((64'd1 << DataWidth) - 64'd1);
    x = 64'(a_in) & width_mask;
    y = 64'(b_in) & width_mask;
    if (x == 0) begin
      return y[FieldWidth-1:0];
    end
    if (y == 0) begin
      return x[FieldWidth-1:0];
    end
    twos = 0;
    while (x[0] == 1'b0 && y[0] == 1'b0) begin
      x = x >> 1;
      y = y >> 1;
      twos++;
    end
    while (x[0] == 1'b0) begin
      x = x >> 1;
    end
    // From here x is odd and y is nonzero until the difference vanishes.
    while (y != 0) begin
      while (y[0] == 1'b0) begin
        y = y >> 1;
      end
      if (x > y) begin
        t = x;
        x = y;
        y = t;
      end
      y = y - x;
    end
    g = (x << twos) & width_mask;
    return g[FieldWidth-1:0];
  endfunction

  task automatic queue_pair(logic [FieldWidth-1:0] a, logic [FieldWidth-1:0] b);
    operand_pair_t p;
    p.a = a;
    p.b = b;
    pending_pairs.push_back(p);
  endtask

  task automatic report_mismatch(string what, logic [FieldWidth-1:0] want,
                                 logic [FieldWidth-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("MISMATCH at %0t: %s, expected 0x%08h, got 0x%08h", $realtime, what, want,
               got);
    end
  endtask

  // Driver. A pair stays on the ports with start high until it is transferred.
  // Between transfers the sender idles at random, except for one long stretch of
  // the random part, and the operand ports carry junk while start is low so that
  // the unit is seen to ignore them.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (pending_pairs.size() != 0 &&
          ((driven_count >= directed_count + 300 && driven_count < directed_count + 450) ||
           $urandom_range(99) >= 36)) begin
        next_pair = pending_pairs.pop_front();
        start     <= 1'b1;
        operand_a <= next_pair.a;
        operand_b <= next_pair.b;
        driven_count++;
      end else begin
        start     <= 1'b0;
        operand_a <= $urandom;
        operand_b <= $urandom;
      end
    end
  end

  // Monitor. The done strobe of one item may coincide with the transfer of the
  // next, so the result is checked before the new prediction is queued.
  always @(posedge clk) begin
    if (rst) begin
      taken <= 1'b0;
    end else begin
      taken <= start && !busy;
      if (done) begin
        if (expected_divisors.size() == 0) begin
          report_mismatch("done strobe with no transfer outstanding", '0, divisor);
        end else begin
          if (divisor !== expected_divisors[0]) begin
            report_mismatch("divisor", expected_divisors[0], divisor);
          end
          void'(expected_divisors.pop_front());
          checked_count++;
        end
      end
      if (start && !busy) begin
        expected_divisors.push_back(gcd_of(operand_a, operand_b));
        accepted_count++;
        if (operand_a == '0 || operand_b == '0) begin
          zero_operand_count++;
        end else if (!operand_a[0] && !operand_b[0]) begin
          shared_two_count++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [FieldWidth-1:0] x;
    logic [FieldWidth-1:0] y;
    logic [FieldWidth-1:0] m;
    int unsigned           r;
    int unsigned           k;

    // Directed part: zero operands, field extremes, powers of two, equal and
    // swapped operands, and a pair of consecutive Fibonacci numbers for the
    // longest subtract loop.
    queue_pair(32'h0000_0000, 32'h0000_0000);
    queue_pair(32'h0000_0000, 32'h0000_0001);
    queue_pair(32'h0000_0001, 32'h0000_0000);
    queue_pair(32'h0000_0000, 32'hFFFF_FFFF);
    queue_pair(32'hFFFF_FFFF, 32'h0000_0000);
    queue_pair(32'h0000_0000, 32'h8000_0000);
    queue_pair(32'h0000_0001, 32'h0000_0001);
    queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_pair(32'h0000_0001, 32'hFFFF_FFFF);
    queue_pair(32'hFFFF_FFFF, 32'h0000_0001);
    queue_pair(32'h8000_0000, 32'h8000_0000);
    queue_pair(32'h8000_0000, 32'h0000_0001);
    queue_pair(32'h8000_0000, 32'hC000_0000);
    queue_pair(32'h7FFF_FFFF, 32'h8000_0000);
    queue_pair(32'hFFFF_FFFE, 32'h0000_0002);
    queue_pair(32'hAAAA_AAAA, 32'h5555_5555);
    queue_pair(32'd2971215073, 32'd1836311903);
    queue_pair(32'd1836311903, 32'd2971215073);
    queue_pair(32'd48, 32'd18);
    queue_pair(32'd18, 32'd48);
    queue_pair(32'd4294967291, 32'd4294967279);
    queue_pair(32'h0001_0000, 32'h0000_0100);
    directed_count = pending_pairs.size();

    // Random part, weighted toward pairs with common factors so the shared-two
    // and subtract phases run long.
    repeat (900) begin
      r = $urandom_range(99);
      if (r < 35) begin
        x = $urandom;
        y = $urandom;
      end else if (r < 55) begin
        k = $urandom_range(31);
        x = $urandom << k;
        y = $urandom << k;
      end else if (r < 70) begin
        m = $urandom_range(65535, 1) << $urandom_range(8);
        x = m * $urandom_range(65535);
        y = m * $urandom_range(65535);
      end else if (r < 80) begin
        x = $urandom >> $urandom_range(31);
        y = '0;
        if ($urandom_range(1) == 1) begin
          y = x;
          x = '0;
        end
      end else if (r < 90) begin
        x = $urandom >> $urandom_range(31);
        y = x << $urandom_range(4);
        if ($urandom_range(1) == 1) begin
          m = x;
          x = y;
          y = m;
        end
      end else begin
        x = 32'h1 << $urandom_range(31);
        y = ~(32'h1 << $urandom_range(31));
        if ($urandom_range(1) == 1) begin
          y = 32'h1 << $urandom_range(31);
        end
      end
      queue_pair(x, y);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every pair to be transferred, then for every result, then give
    // the unit time to show any stray strobe.
    while (pending_pairs.size() != 0 || start) @(posedge clk);
    while (expected_divisors.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (expected_divisors.size() != 0) begin
      report_mismatch("result never shown", expected_divisors[0], '0);
      mismatches += expected_divisors.size() - 1;
    end
    if (mismatches > 10) begin
      $display("%0d further mismatches were counted but not shown.", mismatches - 10);
    end

    $display("Transferred %0d operand pairs (%0d directed) and checked %0d divisors.",
             accepted_count, directed_count, checked_count);
    $display("Of these, %0d had a zero operand and %0d shared a factor of two.",
             zero_operand_count, shared_two_count);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #15_000_000;
    $display("Run timed out with %0d pairs pending and %0d results outstanding.",
             pending_pairs.size(), expected_divisors.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
